@@ rtl/vn_pkg.sv @@
// ----------------------------------------------------------------------------
// vn_pkg: shared types and constants for the 3D vector normalizer
// Holds the lane count, the result width and the control struct that
// travels with every vector down the pipeline.
// ----------------------------------------------------------------------------
`default_nettype none

package vn_pkg;

    localparam int LANES     = 3;
    localparam int OUT_WIDTH = 32;

    // Control that rides along with each vector
    typedef struct packed {
        logic             valid;
        logic             zero;
        logic [LANES-1:0] neg;
    } vn_ctrl_t;

endpackage

`default_nettype wire

@@ rtl/vn_front.sv @@
// ----------------------------------------------------------------------------
// vn_front: magnitude, square and sum stages
// Takes the signed components apart into sign and magnitude, squares them,
// sums the squares and seeds the residual and cross-term of every lane.
// ----------------------------------------------------------------------------
`default_nettype none

module vn_front #(
    parameter int IN_WIDTH  = 24,
    parameter int FRAC_BITS = 30,
    parameter int W         = 2 * IN_WIDTH + 2 * FRAC_BITS + 8
) (
    input  wire logic                    aclk,
    input  wire logic                    aresetn,
    input  wire logic                    en,
    input  wire logic                    in_valid,
    input  wire logic [2:0][IN_WIDTH-1:0] in_comp,
    output vn_pkg::vn_ctrl_t             ctrl_out,
    output logic      [W-1:0]            sum_out,
    output logic      [2:0][W-1:0]       d_out,
    output logic      [2:0][W-1:0]       p_out
);
    import vn_pkg::*;

    localparam int SQW = 2 * IN_WIDTH;

    logic [2:0][IN_WIDTH-1:0] mag_reg;
    logic [2:0]               neg_a_reg, neg_b_reg, neg_c_reg;
    logic                     val_a_reg, val_b_reg, val_c_reg;
    logic [2:0][SQW-1:0]      sq_reg;
    logic [W-1:0]             sum_reg;
    logic [2:0][W-1:0]        d_reg, p_reg;
    logic [W-1:0]             sum_next;

    // Valid bits
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            val_a_reg <= 1'b0;
            val_b_reg <= 1'b0;
            val_c_reg <= 1'b0;
        end else if (en) begin
            val_a_reg <= in_valid;
            val_b_reg <= val_a_reg;
            val_c_reg <= val_b_reg;
        end
    end

    assign sum_next = W'(sq_reg[0]) + W'(sq_reg[1]) + W'(sq_reg[2]);

    // Payload stages
    always_ff @(posedge aclk) begin
        if (en) begin
            for (int i = 0; i < LANES; i++) begin
                neg_a_reg[i] <= in_comp[i][IN_WIDTH-1];
                mag_reg[i]   <= in_comp[i][IN_WIDTH-1] ? (~in_comp[i] + 1'b1) : in_comp[i];
                sq_reg[i]    <= SQW'(mag_reg[i]) * SQW'(mag_reg[i]);
                d_reg[i]     <= (W'(sq_reg[i]) << (2 * FRAC_BITS + 2)) - sum_next;
                p_reg[i]     <= W'(0) - sum_next;
            end
            neg_b_reg <= neg_a_reg;
            neg_c_reg <= neg_b_reg;
            sum_reg   <= sum_next;
        end
    end

    assign ctrl_out.valid = val_c_reg;
    assign ctrl_out.zero  = (sum_reg == '0);
    assign ctrl_out.neg   = neg_c_reg;
    assign sum_out        = sum_reg;
    assign d_out          = d_reg;
    assign p_out          = p_reg;

endmodule

`default_nettype wire

@@ rtl/vn_cell.sv @@
// ----------------------------------------------------------------------------
// vn_cell: one quotient bit of the rounded scaled magnitude
// Tries setting bit BIT of q in every lane: keeps it when the residual
// R - (2q-1)^2 * S stays non-negative, and updates the cross-term (2q-1)*S.
// ----------------------------------------------------------------------------
`default_nettype none

module vn_cell #(
    parameter int FRAC_BITS = 30,
    parameter int W         = 116,
    parameter int BIT       = 0
) (
    input  wire logic                     aclk,
    input  wire logic                     aresetn,
    input  wire logic                     en,
    input  vn_pkg::vn_ctrl_t              ctrl_in,
    input  wire logic [W-1:0]             sum_in,
    input  wire logic [2:0][W-1:0]        d_in,
    input  wire logic [2:0][W-1:0]        p_in,
    input  wire logic [2:0][FRAC_BITS:0]  q_in,
    output vn_pkg::vn_ctrl_t              ctrl_out,
    output logic      [W-1:0]             sum_out,
    output logic      [2:0][W-1:0]        d_out,
    output logic      [2:0][W-1:0]        p_out,
    output logic      [2:0][FRAC_BITS:0]  q_out
);
    import vn_pkg::*;

    logic                    valid_reg;
    logic                    zero_reg;
    logic [LANES-1:0]        neg_reg;
    logic [W-1:0]            sum_reg;
    logic [2:0][W-1:0]       d_reg, p_reg;
    logic [2:0][FRAC_BITS:0] q_reg;
    logic [2:0][W-1:0]       trial;

    // Trial residual per lane
    always_comb begin
        for (int i = 0; i < LANES; i++) begin
            trial[i] = d_in[i] - (p_in[i] << (BIT + 2)) - (sum_in << (2 * BIT + 2));
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (en) begin
            valid_reg <= ctrl_in.valid;
        end
    end

    // Keep the bit where the residual stays non-negative
    always_ff @(posedge aclk) begin
        if (en) begin
            zero_reg <= ctrl_in.zero;
            neg_reg  <= ctrl_in.neg;
            sum_reg  <= sum_in;
            for (int i = 0; i < LANES; i++) begin
                if (!trial[i][W-1]) begin
                    d_reg[i] <= trial[i];
                    p_reg[i] <= p_in[i] + (sum_in << (BIT + 1));
                    q_reg[i] <= q_in[i] | ((FRAC_BITS+1)'(1) << BIT);
                end else begin
                    d_reg[i] <= d_in[i];
                    p_reg[i] <= p_in[i];
                    q_reg[i] <= q_in[i];
                end
            end
        end
    end

    assign ctrl_out.valid = valid_reg;
    assign ctrl_out.zero  = zero_reg;
    assign ctrl_out.neg   = neg_reg;
    assign sum_out        = sum_reg;
    assign d_out          = d_reg;
    assign p_out          = p_reg;
    assign q_out          = q_reg;

endmodule

`default_nettype wire

@@ rtl/vector3_normalize.sv @@
// Path: vn_front magnitude, square and sum registers, the cell chain, then the output register.
// Throughput: one vector per cycle; the pipeline moves whenever the output
// register is empty or being taken, one cell per quotient bit.
// Reset: synchronous active-low aresetn clears all valid bits; payload
// registers keep whatever they hold.
// ----------------------------------------------------------------------------
// vector3_normalize: 3D vector normalization to signed fixed point
// Squares and sums the components, then resolves each component scaled by
// 1/sqrt(sum), rounded to nearest, one bit per cell along a chain of cells.
// ----------------------------------------------------------------------------
`default_nettype none

module vector3_normalize #(
    parameter int IN_WIDTH  = 24,
    parameter int FRAC_BITS = 30
) (
    input  wire logic                                aclk,
    input  wire logic                                aresetn,
    input  wire logic                                s_tvalid,
    output logic                                     s_tready,
    // x_in, y_in, z_in from the lowest bit, zero filled to bytes
    input  wire logic [(3*IN_WIDTH+7)/8*8-1:0]       s_tdata,
    output logic                                     m_tvalid,
    input  wire logic                                m_tready,
    // x_unit, y_unit, z_unit from the lowest bit
    output logic [3*vn_pkg::OUT_WIDTH-1:0]           m_tdata,
    // zero_vector
    output logic                                     m_tuser
);
    import vn_pkg::*;

    localparam int W      = 2 * IN_WIDTH + 2 * FRAC_BITS + 8;
    localparam int NCELLS = FRAC_BITS + 1;

    logic                      en;
    logic [2:0][IN_WIDTH-1:0]  comp;
    vn_ctrl_t                  ctrl   [NCELLS+1];
    logic [W-1:0]              sum    [NCELLS+1];
    logic [2:0][W-1:0]         d      [NCELLS+1];
    logic [2:0][W-1:0]         p      [NCELLS+1];
    logic [2:0][FRAC_BITS:0]   q      [NCELLS+1];
    logic                      out_valid_reg;
    logic [3*OUT_WIDTH-1:0]    out_data_reg;
    logic                      out_zero_reg;
    logic [3*OUT_WIDTH-1:0]    out_data_next;

    // Advance whenever the output slot is free or being drained
    assign en       = !out_valid_reg || m_tready;
    assign s_tready = en;

    always_comb begin
        for (int i = 0; i < LANES; i++) begin
            comp[i] = s_tdata[i*IN_WIDTH +: IN_WIDTH];
        end
    end

    vn_front #(.IN_WIDTH(IN_WIDTH), .FRAC_BITS(FRAC_BITS), .W(W)) u_front (
        .aclk(aclk), .aresetn(aresetn), .en(en),
        .in_valid(s_tvalid), .in_comp(comp),
        .ctrl_out(ctrl[0]), .sum_out(sum[0]), .d_out(d[0]), .p_out(p[0])
    );

    assign q[0] = '0;

    // One cell per quotient bit, most significant first
    for (genvar k = 0; k < NCELLS; k++) begin : g_cell
        vn_cell #(.FRAC_BITS(FRAC_BITS), .W(W), .BIT(FRAC_BITS - k)) u_cell (
            .aclk(aclk), .aresetn(aresetn), .en(en),
            .ctrl_in(ctrl[k]), .sum_in(sum[k]), .d_in(d[k]), .p_in(p[k]), .q_in(q[k]),
            .ctrl_out(ctrl[k+1]), .sum_out(sum[k+1]), .d_out(d[k+1]),
            .p_out(p[k+1]), .q_out(q[k+1])
        );
    end

    // Apply signs, force zero for a zero vector
    always_comb begin
        for (int i = 0; i < LANES; i++) begin
            if (ctrl[NCELLS].zero) begin
                out_data_next[i*OUT_WIDTH +: OUT_WIDTH] = '0;
            end else if (ctrl[NCELLS].neg[i]) begin
                out_data_next[i*OUT_WIDTH +: OUT_WIDTH] =
                    OUT_WIDTH'(0) - OUT_WIDTH'(q[NCELLS][i]);
            end else begin
                out_data_next[i*OUT_WIDTH +: OUT_WIDTH] = OUT_WIDTH'(q[NCELLS][i]);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (en) begin
            out_valid_reg <= ctrl[NCELLS].valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            out_data_reg <= out_data_next;
            out_zero_reg <= ctrl[NCELLS].zero;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tuser  = out_zero_reg;

    // A zero vector yields all-zero components
    a_zero_out: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser |-> m_tdata == '0)
        else $error("zero vector with nonzero components");

    // The x component never exceeds one in magnitude
    a_x_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> ($signed(m_tdata[OUT_WIDTH-1:0]) <= $signed(OUT_WIDTH'(1) << FRAC_BITS)
                   && $signed(m_tdata[OUT_WIDTH-1:0]) >= -$signed(OUT_WIDTH'(1) << FRAC_BITS)))
        else $error("x_unit out of range");

    // A drained output slot lets the pipeline take a new transaction
    a_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        (!m_tvalid || m_tready) |-> s_tready)
        else $error("stalled while output free");

    // A result waiting unaccepted is held
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("pending result changed");

endmodule

`default_nettype wire

@@ dv/testbench.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: self-checking bench for vector3_normalize
// Drives 3D vectors over the input stream and compares every unit vector on
// the result stream against a bit-exact integer predictor of 1/sqrt scaling.
// ----------------------------------------------------------------------------
`default_nettype none

module testbench;

    localparam int IN_W     = 24;
    localparam int FRAC     = 30;
    localparam int DATA_W   = (3*IN_W+7)/8*8;
    localparam int OUT_W    = vn_pkg::OUT_WIDTH;
    localparam int LATENCY  = FRAC + 5;
    localparam int MAX_CYC  = 400000;

    typedef struct packed {
        logic [OUT_W-1:0] x;
        logic [OUT_W-1:0] y;
        logic [OUT_W-1:0] z;
        logic             zero;
    } unit_vec_t;

    logic              aclk = 1'b0;
    logic              aresetn = 1'b0;
    logic              s_tvalid = 1'b0;
    logic              s_tready;
    logic [DATA_W-1:0] s_tdata = '0;
    logic              m_tvalid;
    logic              m_tready = 1'b0;
    logic [3*OUT_W-1:0] m_tdata;
    logic              m_tuser;

    unit_vec_t unit_q[$];
    int        mismatches = 0;
    int        cycles = 0;
    bit        quiet = 1'b0;
    bit        sink_busy = 1'b0;

    vector3_normalize #(.IN_WIDTH(IN_W), .FRAC_BITS(FRAC)) u_dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready),
        .m_tdata(m_tdata), .m_tuser(m_tuser)
    );

    always #1 aclk = ~aclk;

    // Bound the run
    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles > MAX_CYC) begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    // Largest q with (2q-1)^2 * sum <= 4 * mag^2 * 4^FRAC, i.e. round-to-nearest
    function automatic logic [OUT_W-1:0] scale_mag(logic [IN_W-1:0] mag,
                                                   logic [63:0] sum);
        logic [191:0] rhs;
        logic [191:0] lhs;
        logic [63:0]  q;
        logic [63:0]  cand;
        logic [63:0]  odd;
        rhs = ({128'd0, mag} * {128'd0, mag}) << (2*FRAC + 2);
        q = 0;
        if (mag == 0) return '0;
        for (int b = FRAC; b >= 0; b--) begin
            cand = q | (64'd1 << b);
            odd  = 2*cand - 1;
            lhs  = {128'd0, odd} * {128'd0, odd} * {128'd0, sum};
            if (lhs <= rhs) q = cand;
        end
        return q[OUT_W-1:0];
    endfunction

    function automatic unit_vec_t normalize(logic [IN_W-1:0] cx, logic [IN_W-1:0] cy,
                                            logic [IN_W-1:0] cz);
        logic [IN_W-1:0]  comp[3];
        logic [IN_W-1:0]  mag[3];
        logic [OUT_W-1:0] res[3];
        logic [63:0]      sum;
        unit_vec_t        u;
        comp[0] = cx; comp[1] = cy; comp[2] = cz;
        sum = 0;
        for (int i = 0; i < 3; i++) begin
            mag[i] = comp[i][IN_W-1] ? -comp[i] : comp[i];
            sum += {40'd0, mag[i]} * {40'd0, mag[i]};
        end
        if (sum == 0) return '{x: '0, y: '0, z: '0, zero: 1'b1};
        for (int i = 0; i < 3; i++) begin
            res[i] = scale_mag(mag[i], sum);
            if (comp[i][IN_W-1]) res[i] = -res[i];
        end
        u = '{x: res[0], y: res[1], z: res[2], zero: 1'b0};
        return u;
    endfunction

    task automatic report(string what, logic [OUT_W-1:0] got, logic [OUT_W-1:0] want);
        $display("mismatch %s: got %0h expected %0h", what, got, want);
        mismatches++;
    endtask

    // Check each result transaction against the oldest expected unit vector
    always @(posedge aclk) begin
        unit_vec_t w;
        if (aresetn && m_tvalid && m_tready) begin
            if (unit_q.size() == 0) begin
                report("unexpected result", m_tdata[OUT_W-1:0], '0);
            end else begin
                w = unit_q.pop_front();
                if (m_tdata[OUT_W-1:0] !== w.x) report("x_unit", m_tdata[OUT_W-1:0], w.x);
                if (m_tdata[2*OUT_W-1:OUT_W] !== w.y)
                    report("y_unit", m_tdata[2*OUT_W-1:OUT_W], w.y);
                if (m_tdata[3*OUT_W-1:2*OUT_W] !== w.z)
                    report("z_unit", m_tdata[3*OUT_W-1:2*OUT_W], w.z);
                if (m_tuser !== w.zero)
                    report("zero_vector", OUT_W'(m_tuser), OUT_W'(w.zero));
            end
        end
    end

    // Stall the result side in random bursts
    always @(negedge aclk) begin
        if (quiet || !aresetn) begin
            m_tready <= aresetn;
        end else if (!sink_busy && $urandom_range(0, 3) == 0) begin
            sink_busy = 1'b1;
            m_tready <= 1'b0;
            fork begin
                repeat ($urandom_range(1, 8)) @(negedge aclk);
                sink_busy = 1'b0;
            end join_none
        end else if (!sink_busy) begin
            m_tready <= 1'b1;
        end
    end

    // Valid stays high after a transaction until the next one or an idle gap
    task automatic send_vector(logic [IN_W-1:0] cx, logic [IN_W-1:0] cy,
                               logic [IN_W-1:0] cz);
        if (!quiet && $urandom_range(0, 5) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(negedge aclk);
        end
        s_tdata  <= {{(DATA_W-3*IN_W){1'b0}}, cz, cy, cx};
        s_tvalid <= 1'b1;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        unit_q.push_back(normalize(cx, cy, cz));
        @(negedge aclk);
    endtask

    function automatic logic [IN_W-1:0] rand_comp();
        case ($urandom_range(0, 5))
            0: return IN_W'($urandom_range(0, 15));
            1: return IN_W'(-$urandom_range(0, 15));
            2: return IN_W'({1'b1, {(IN_W-1){1'b0}}} + $urandom_range(0, 3));
            3: return IN_W'({1'b0, {(IN_W-1){1'b1}}} - $urandom_range(0, 3));
            default: return IN_W'($urandom());
        endcase
    endfunction

    task automatic test_extremes();
        logic [IN_W-1:0] mx;
        logic [IN_W-1:0] mn;
        mx = {1'b0, {(IN_W-1){1'b1}}};
        mn = {1'b1, {(IN_W-1){1'b0}}};
        send_vector('0, '0, '0);
        send_vector(IN_W'(1), '0, '0);
        send_vector('0, '1, '0);
        send_vector('0, '0, mn);
        send_vector(mx, mx, mx);
        send_vector(mn, mn, mn);
        send_vector(mx, mn, '0);
        send_vector(mn, IN_W'(1), '1);
        send_vector(IN_W'(1), IN_W'(1), '0);
        send_vector(IN_W'(3), IN_W'(4), '0);
        send_vector(IN_W'(-3), '0, IN_W'(-4));
        send_vector(IN_W'(2), IN_W'(3), IN_W'(6));
        send_vector(IN_W'(1), IN_W'(1), IN_W'(1));
        send_vector(mx, IN_W'(1), '0);
        send_vector('1, '1, '1);
        send_vector('1, '0, '1);
        send_vector(24'h555555, 24'haaaaaa, 24'h0f0f0f);
    endtask

    task automatic test_random(int n);
        for (int i = 0; i < n; i++)
            send_vector(rand_comp(), rand_comp(), rand_comp());
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        while (unit_q.size() != 0) @(posedge aclk);
        repeat (LATENCY + 5) @(posedge aclk);
        @(negedge aclk);
    endtask

    initial begin
        repeat (7) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        test_extremes();
        test_random(600);
        // Hold input until the pipeline has emptied
        drain();
        test_random(700);
        quiet = 1'b1;
        test_random(450);
        drain();
        if (mismatches == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule

`default_nettype wire

@@ files.f @@
rtl/vn_pkg.sv
rtl/vn_front.sv
rtl/vn_cell.sv
rtl/vector3_normalize.sv
dv/testbench.sv
